// File: hw/rtl/cv3x3_pkg.sv
// cv3x3_pkg: shared types, constants and helpers of the 3x3 rgb filter
// used by the ctrl, window and mac rtl files and the top level; depends on nothing

package cv3x3_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 10;

    // fixed field widths
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_IDX_W = 3;

    // geometry after reset
    localparam int FW_RESET = 1024;
    localparam int FH_RESET = 1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } cfg_reg_t;

    // item kinds
    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // nine taps, index row * 3 + column, top left first
    typedef logic [8:0][PIX_W-1:0] window_t;

    // line store control, one set per accepted item
    typedef struct packed {
        logic shift;   // item takes part in the stream
        logic write;   // real pixel, stored in the line store
        logic wr_sel;  // line store written by the current row
    } line_ctl_t;

    // border replication flags of the output position
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } clamp_t;

    // width of the configuration data bus
    function automatic int cfg_width(input int coef_bits);
        return (3 * coef_bits > FH_W) ? 3 * coef_bits : FH_W;
    endfunction

endpackage

// File: hw/rtl/cv3x3_in_if.sv
// cv3x3_in_if: valid/ready channel carrying input items of the filter
// depends on nothing

interface cv3x3_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output req_type, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input req_type, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

// File: hw/rtl/cv3x3_out_if.sv
// cv3x3_out_if: valid/ready channel carrying filtered result items
// depends on nothing

interface cv3x3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_last, output ready);
endinterface

// File: hw/rtl/cv3x3_ctrl.sv
// cv3x3_ctrl: frame geometry registers, raster counters and window stage valid
// depends on cv3x3_pkg

module cv3x3_ctrl #(
    parameter int MAX_WIDTH = cv3x3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              req_type,
    input  logic                              cfg_we,
    input  logic [cv3x3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cv3x3_pkg::FH_W-1:0]        cfg_data,
    input  logic                              s1_take,
    output cv3x3_pkg::line_ctl_t              line_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]      col_addr,
    output logic                              s1_valid,
    output cv3x3_pkg::clamp_t                 s1_flags
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WCOL_W   = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W    = $clog2(MAX_WIDTH + 2);
    localparam int WidthRst = (cv3x3_pkg::FW_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : cv3x3_pkg::FW_RESET;

    logic [WCOL_W-1:0]          w_eff_reg, w_eff_next;
    logic [cv3x3_pkg::FH_W-1:0] h_eff_reg, h_eff_next;
    logic [COL_W-1:0]           in_col_reg, in_col_next;
    logic [cv3x3_pkg::FH_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]           out_col_reg, out_col_next;
    logic [cv3x3_pkg::FH_W-1:0] out_row_reg, out_row_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       full_reg, full_next;
    logic                       sel_reg, sel_next;
    logic                       s1_valid_reg, s1_valid_next;
    cv3x3_pkg::clamp_t          s1_flags_reg, s1_flags_next;

    logic [cv3x3_pkg::FW_W-1:0] fw;
    logic                       is_pix;
    logic                       active;
    logic                       emit;
    logic                       col_end;
    logic                       row_end;
    cv3x3_pkg::clamp_t          flags;

    always_comb
    begin
        fw      = cfg_data[cv3x3_pkg::FW_W-1:0];
        is_pix  = (cv3x3_pkg::req_t'(req_type) == cv3x3_pkg::REQ_PIXEL) && !full_reg;
        active  = accept && (is_pix || full_reg);
        emit    = active && (cnt_reg == (CNT_W'(w_eff_reg) + CNT_W'(1)));
        col_end = WCOL_W'(in_col_reg) == (w_eff_reg - WCOL_W'(1));
        row_end = in_row_reg == (h_eff_reg - 16'd1);

        flags.top    = out_row_reg == '0;
        flags.bottom = out_row_reg == (h_eff_reg - 16'd1);
        flags.left   = out_col_reg == '0;
        flags.right  = WCOL_W'(out_col_reg) == (w_eff_reg - WCOL_W'(1));
        flags.last   = flags.bottom && flags.right;

        w_eff_next    = w_eff_reg;
        h_eff_next    = h_eff_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        cnt_next      = cnt_reg;
        full_next     = full_reg;
        sel_next      = sel_reg;
        s1_valid_next = s1_valid_reg;
        s1_flags_next = s1_flags_reg;

        if (active)
        begin
            // input position; drain ticks only walk the column for the read side
            if (col_end)
            begin
                in_col_next = '0;
                if (is_pix)
                begin
                    sel_next = !sel_reg;
                    if (row_end)
                    begin
                        in_row_next = '0;
                        full_next   = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + 16'd1;
                    end
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (emit)
            begin
                if (flags.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    cnt_next     = '0;
                    full_next    = 1'b0;
                end
                else if (flags.right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 16'd1;
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (accept)
        begin
            s1_valid_next = emit;
            s1_flags_next = flags;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end

        // geometry writes restart the frame
        if (cfg_we)
        begin
            case (cv3x3_pkg::cfg_reg_t'(cfg_index))
                cv3x3_pkg::REG_FRAME_WIDTH:
                begin
                    if (fw == '0)
                        w_eff_next = WCOL_W'(1);
                    else if (32'(fw) > MAX_WIDTH)
                        w_eff_next = WCOL_W'(MAX_WIDTH);
                    else
                        w_eff_next = WCOL_W'(fw);
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    cnt_next     = '0;
                    full_next    = 1'b0;
                end
                cv3x3_pkg::REG_FRAME_HEIGHT:
                begin
                    h_eff_next   = (cfg_data == '0) ? 16'd1 : cfg_data;
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    cnt_next     = '0;
                    full_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg    <= WCOL_W'(WidthRst);
            h_eff_reg    <= 16'(cv3x3_pkg::FH_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            cnt_reg      <= '0;
            full_reg     <= 1'b0;
            sel_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg    <= w_eff_next;
            h_eff_reg    <= h_eff_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            cnt_reg      <= cnt_next;
            full_reg     <= full_next;
            sel_reg      <= sel_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_flags_reg <= s1_flags_next;
    end

    assign line_ctl.shift  = active;
    assign line_ctl.write  = accept && is_pix;
    assign line_ctl.wr_sel = sel_reg;
    assign col_addr        = in_col_reg;
    assign s1_valid        = s1_valid_reg;
    assign s1_flags        = s1_flags_reg;

endmodule

// File: hw/rtl/cv3x3_window.sv
// cv3x3_window: two line stores, column shift registers and border replication
// depends on cv3x3_pkg

module cv3x3_window #(
    parameter int MAX_WIDTH = cv3x3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  cv3x3_pkg::line_ctl_t          line_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col_addr,
    input  cv3x3_pkg::pixel_t             pix,
    input  cv3x3_pkg::clamp_t             flags,
    output cv3x3_pkg::window_t            taps
);

    typedef struct packed {
        cv3x3_pkg::pixel_t top;
        cv3x3_pkg::pixel_t mid;
        cv3x3_pkg::pixel_t bot;
    } column_t;

    // one row per store, rows alternate between them
    cv3x3_pkg::pixel_t line_a_mem [MAX_WIDTH];
    cv3x3_pkg::pixel_t line_b_mem [MAX_WIDTH];

    cv3x3_pkg::pixel_t rd_a_reg;
    cv3x3_pkg::pixel_t rd_b_reg;
    cv3x3_pkg::pixel_t t0_bot_reg;
    logic              t0_sel_reg;
    column_t           t1_reg;
    column_t           t2_reg;

    column_t           t0;
    column_t           col_l;
    column_t           col_c;
    column_t           col_r;
    column_t           cols [3];

    // read-first: the entry being overwritten comes out as the oldest row
    always_ff @(posedge clk)
    begin
        if (line_ctl.write && !line_ctl.wr_sel)
            line_a_mem[col_addr] <= pix;
        if (line_ctl.shift)
            rd_a_reg <= line_a_mem[col_addr];
    end

    always_ff @(posedge clk)
    begin
        if (line_ctl.write && line_ctl.wr_sel)
            line_b_mem[col_addr] <= pix;
        if (line_ctl.shift)
            rd_b_reg <= line_b_mem[col_addr];
    end

    always_ff @(posedge clk)
    begin
        if (line_ctl.shift)
        begin
            t0_bot_reg <= pix;
            t0_sel_reg <= line_ctl.wr_sel;
            t1_reg     <= t0;
            t2_reg     <= t1_reg;
        end
    end

    always_comb
    begin
        t0.bot = t0_bot_reg;
        t0.top = t0_sel_reg ? rd_b_reg : rd_a_reg;
        t0.mid = t0_sel_reg ? rd_a_reg : rd_b_reg;

        col_l = flags.left  ? t1_reg : t2_reg;
        col_c = t1_reg;
        col_r = flags.right ? t1_reg : t0;

        cols[0] = col_l;
        cols[1] = col_c;
        cols[2] = col_r;

        for (int c = 0; c < 3; c++)
        begin
            taps[c]     = flags.top    ? cols[c].mid : cols[c].top;
            taps[3 + c] = cols[c].mid;
            taps[6 + c] = flags.bottom ? cols[c].mid : cols[c].bot;
        end
    end

endmodule

// File: hw/rtl/cv3x3_mac.sv
// cv3x3_mac: coefficient products, channel sums, saturation and result register
// depends on cv3x3_pkg and cv3x3_out_if

module cv3x3_mac #(
    parameter int COEF_BITS = cv3x3_pkg::COEF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [2:0][3*COEF_BITS-1:0]   kernel,
    input  cv3x3_pkg::window_t            taps,
    input  logic                          s1_valid,
    input  logic                          s1_last,
    output logic                          s2_ready,
    cv3x3_out_if.source                   filtered
);

    localparam int PROD_W = COEF_BITS + cv3x3_pkg::CH_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    logic signed [PROD_W-1:0] prod_reg  [3][9];
    logic signed [PROD_W-1:0] prod_next [3][9];
    logic                     s2_valid_reg;
    logic                     s2_last_reg;

    logic [cv3x3_pkg::CH_W-1:0] chan_reg  [3];
    logic [cv3x3_pkg::CH_W-1:0] chan_next [3];
    logic                       last_reg;
    logic                       out_valid_reg;

    logic                       out_free;
    logic                       s2_load;
    logic signed [SUM_W-1:0]    sum [3];

    assign out_free = !out_valid_reg || filtered.ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s2_load  = s1_valid && s2_ready;

    // 27 small products, one per tap and channel
    always_comb
    begin
        logic signed [COEF_BITS-1:0]       k;
        logic signed [cv3x3_pkg::CH_W:0]   p;
        for (int i = 0; i < 9; i++)
        begin
            k = kernel[i / 3][(i % 3) * COEF_BITS +: COEF_BITS];
            for (int ch = 0; ch < 3; ch++)
            begin
                p = {1'b0, taps[i][cv3x3_pkg::PIX_W - 1 - cv3x3_pkg::CH_W * ch -: 8]};
                prod_next[ch][i] = k * p;
            end
        end
    end

    // sum and clamp to a byte
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int i = 0; i < 9; i++)
                sum[ch] = sum[ch] + SUM_W'(prod_reg[ch][i]);
            if (sum[ch] < 0)
                chan_next[ch] = '0;
            else if (sum[ch] > SUM_W'(255))
                chan_next[ch] = 8'hFF;
            else
                chan_next[ch] = sum[ch][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= s1_valid;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            prod_reg    <= prod_next;
            s2_last_reg <= s1_last;
        end
        if (out_free && s2_valid_reg)
        begin
            chan_reg <= chan_next;
            last_reg <= s2_last_reg;
        end
    end

    assign filtered.valid      = out_valid_reg;
    assign filtered.out_red    = chan_reg[0];
    assign filtered.out_green  = chan_reg[1];
    assign filtered.out_blue   = chan_reg[2];
    assign filtered.frame_last = last_reg;

endmodule

// File: hw/rtl/conv3x3_rgb_clamp_edge_core.sv
// conv3x3_rgb_clamp_edge_core: streaming 3x3 rgb filter with replicated borders
// a result moves through the window stage, product and output registers in that order
// one item per clock unless stalled; output pixel k leaves with input item k + width + 1
// the stream stalls only when the output is held and both internal stages are full
// reset: counters clear, geometry 1024 x 1024, identity kernel; line stores keep their
// contents (a row is always written before it is read) so there is no clearing pass

module conv3x3_rgb_clamp_edge_core #(
    parameter int MAX_WIDTH = cv3x3_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = cv3x3_pkg::COEF_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    cv3x3_in_if.sink                                      pixel,
    cv3x3_out_if.source                                   filtered,
    input  logic                                          cfg_we,
    input  logic [cv3x3_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [cv3x3_pkg::cfg_width(COEF_BITS)-1:0]    cfg_data
);

    localparam int KROW_W = 3 * COEF_BITS;
    localparam int COL_W  = $clog2(MAX_WIDTH);

    // middle row resets to a single centre tap of one
    localparam logic [KROW_W-1:0] KernelMidRst = KROW_W'(1) << COEF_BITS;

    logic [2:0][KROW_W-1:0]  kernel_reg;

    // handshake between the window stage and the product stage
    logic                    accept;
    logic                    s1_valid;
    logic                    s2_ready;
    cv3x3_pkg::clamp_t       s1_flags;

    // line store control for the accepted item
    cv3x3_pkg::line_ctl_t    line_ctl;
    logic [COL_W-1:0]        col_addr;
    cv3x3_pkg::window_t      taps;

    // the window stage is free, or moves on in this cycle
    assign pixel.ready = !s1_valid || s2_ready;
    assign accept      = pixel.valid && pixel.ready;

    // kernel rows; a write lands before the next item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg[0] <= '0;
            kernel_reg[1] <= KernelMidRst;
            kernel_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cv3x3_pkg::cfg_reg_t'(cfg_index))
                cv3x3_pkg::REG_KERNEL_TOP:    kernel_reg[0] <= cfg_data[KROW_W-1:0];
                cv3x3_pkg::REG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_data[KROW_W-1:0];
                cv3x3_pkg::REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_data[KROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // raster counters: decide which items push pixels and which emit results
    cv3x3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (pixel.req_type),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data[cv3x3_pkg::FH_W-1:0]),
        .s1_take   (s2_ready),
        .line_ctl  (line_ctl),
        .col_addr  (col_addr),
        .s1_valid  (s1_valid),
        .s1_flags  (s1_flags)
    );

    // line stores and the three column registers that make the 3x3 window
    cv3x3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk      (clk),
        .line_ctl (line_ctl),
        .col_addr (col_addr),
        .pix      ({pixel.in_red, pixel.in_green, pixel.in_blue}),
        .flags    (s1_flags),
        .taps     (taps)
    );

    // products, sums, saturation, result register
    cv3x3_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .kernel   (kernel_reg),
        .taps     (taps),
        .s1_valid (s1_valid),
        .s1_last  (s1_flags.last),
        .s2_ready (s2_ready),
        .filtered (filtered)
    );

endmodule

// File: hw/rtl/cv3x3_checker.sv
// cv3x3_checker: port level assertions for the 3x3 rgb filter, bound to the top level
// depends on conv3x3_rgb_clamp_edge_core

module cv3x3_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic       frame_last
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
            && $stable(out_blue) && $stable(frame_last))
        else $error("held result changed");

    // with the output register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // nothing comes out of an empty, unfed pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_acc && !out_valid) ##1 (!in_acc && !out_valid) ##1 (!in_acc && !out_valid)
            |=> !out_valid)
        else $error("result without an item");

    // reset empties the output
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind conv3x3_rgb_clamp_edge_core cv3x3_checker u_cv3x3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .out_valid  (filtered.valid),
    .out_ready  (filtered.ready),
    .out_red    (filtered.out_red),
    .out_green  (filtered.out_green),
    .out_blue   (filtered.out_blue),
    .frame_last (filtered.frame_last)
);

// File: tb/cv3x3_check_pkg.sv
`timescale 1ns / 1ps
// cv3x3_check_pkg: expected-pixel predictor and output checker for the 3x3 rgb filter
// depends on cv3x3_pkg

package cv3x3_check_pkg;
    import cv3x3_pkg::*;

    localparam int LINE_MAX   = MAX_WIDTH_DEF;
    localparam int COEF_W     = COEF_BITS_DEF;
    localparam int CFG_W      = cfg_width(COEF_BITS_DEF);
    localparam int SHOW_LIMIT = 10;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } rgb_result_t;

    class rgb_filter_scoreboard;
        logic [FW_W-1:0]     width_reg;
        logic [FH_W-1:0]     height_reg;
        logic [3*COEF_W-1:0] kernel_rows [3];

        // pixels of the frame in progress, raster order
        pixel_t      frame_px [$];
        bit          frame_full;
        int          stream_items;
        int          out_row;
        int          out_col;
        rgb_result_t awaited_pixels [$];

        int items_taken;
        int drains_ignored;
        int results_seen;
        int frames_done;
        int mismatches;

        function new();
            width_reg      = FW_W'(FW_RESET);
            height_reg     = FH_W'(FH_RESET);
            kernel_rows[0] = '0;
            kernel_rows[1] = (3*COEF_W)'(1) << COEF_W;
            kernel_rows[2] = '0;
            items_taken    = 0;
            drains_ignored = 0;
            results_seen   = 0;
            frames_done    = 0;
            mismatches     = 0;
            start_frame();
        endfunction

        function void start_frame();
            frame_px.delete();
            frame_full   = 1'b0;
            stream_items = 0;
            out_row      = 0;
            out_col      = 0;
        endfunction

        // zero acts as one, anything past the line store acts as its size
        function int active_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > LINE_MAX)
                return LINE_MAX;
            return int'(width_reg);
        endfunction

        function int active_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_FRAME_WIDTH:
                begin
                    width_reg = data[FW_W-1:0];
                    start_frame();
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg = data[FH_W-1:0];
                    start_frame();
                end
                REG_KERNEL_TOP:    kernel_rows[0] = data[3*COEF_W-1:0];
                REG_KERNEL_MIDDLE: kernel_rows[1] = data[3*COEF_W-1:0];
                REG_KERNEL_BOTTOM: kernel_rows[2] = data[3*COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function int tap(int row, int col);
            logic signed [COEF_W-1:0] raw;
            raw = kernel_rows[row][col*COEF_W +: COEF_W];
            return int'(raw);
        endfunction

        function logic [CH_W-1:0] saturate(int v);
            if (v < 0)
                return '0;
            if (v > 255)
                return 8'hFF;
            return CH_W'(v);
        endfunction

        function int clamp(int v, int hi);
            if (v < 0)
                return 0;
            return (v > hi) ? hi : v;
        endfunction

        function void accept_item(req_t kind, pixel_t pix);
            int          w;
            int          h;
            int          rr;
            int          cc;
            int          k;
            int          dr;
            int          dc;
            int          ch;
            int          sum [3];
            pixel_t      p;
            rgb_result_t res;

            items_taken++;
            w = active_width();
            h = active_height();
            if (kind == REQ_PIXEL && !frame_full)
            begin
                frame_px.push_back(pix);
                if (frame_px.size() == w * h)
                    frame_full = 1'b1;
            end
            else if (!frame_full)
            begin
                // drain before the last pixel: no effect at all
                drains_ignored++;
                return;
            end

            stream_items++;
            if (stream_items < w + 2)
                return;

            sum = '{0, 0, 0};
            for (dr = -1; dr <= 1; dr++)
            begin
                for (dc = -1; dc <= 1; dc++)
                begin
                    rr = clamp(out_row + dr, h - 1);
                    cc = clamp(out_col + dc, w - 1);
                    p  = frame_px[rr * w + cc];
                    k  = tap(dr + 1, dc + 1);
                    for (ch = 0; ch < 3; ch++)
                        sum[ch] += k * int'(p[(2 - ch) * CH_W +: CH_W]);
                end
            end

            res.red   = saturate(sum[0]);
            res.green = saturate(sum[1]);
            res.blue  = saturate(sum[2]);
            res.last  = (out_row == h - 1) && (out_col == w - 1);
            awaited_pixels.push_back(res);

            if (res.last)
            begin
                frames_done++;
                start_frame();
            end
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void compare_output(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                     logic [CH_W-1:0] blue, logic last);
            rgb_result_t want;

            results_seen++;
            if (awaited_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("output pixel %0d not expected: r=%0d g=%0d b=%0d last=%0b",
                             results_seen - 1, red, green, blue, last);
                return;
            end
            want = awaited_pixels.pop_front();
            if (red !== want.red || green !== want.green || blue !== want.blue ||
                last !== want.last)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("output pixel %0d: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                             results_seen - 1, want.red, want.green, want.blue, want.last,
                             red, green, blue, last);
            end
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction
    endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of conv3x3_rgb_clamp_edge_core
// depends on cv3x3_pkg, cv3x3_in_if, cv3x3_out_if and cv3x3_check_pkg

module tb;
    import cv3x3_pkg::*;
    import cv3x3_check_pkg::*;

    // idle time after the last awaited pixel so the pipeline registers can empty
    localparam int SETTLE_CYCLES      = 8;
    localparam int LONG_HOLD          = 400;
    localparam int CYCLE_LIMIT        = 1_000_000;
    localparam int RANDOM_PHASE_ITEMS = 300;

    // register indexes past the list, writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_KERNEL_BOTTOM + 1;
    localparam int                   UNMAPPED_COUNT     = (1 << CFG_IDX_W) - REG_UNMAPPED_FIRST;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cv3x3_in_if  pixel_if ();
    cv3x3_out_if filt_if ();

    conv3x3_rgb_clamp_edge_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_if),
        .filtered  (filt_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rgb_filter_scoreboard filter_sb = new();

    // idling percentages of the current phase
    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    bit   hold_active   = 1'b0;
    event long_hold_go;
    int   cycle_count   = 0;
    int   stream_sent   = 0;

    always #5 clk = ~clk;

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
        filt_if.ready <= !hold_active && ($urandom_range(0, 99) >= snk_stall_pct);

    // long hold-off counted here so the sender keeps offering items meanwhile
    always
    begin
        @(long_hold_go);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
    end

    // output checked before the input is noted, so one edge never depends on process order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (filt_if.valid && filt_if.ready)
                filter_sb.compare_output(filt_if.out_red, filt_if.out_green,
                                         filt_if.out_blue, filt_if.frame_last);
            if (pixel_if.valid && pixel_if.ready)
                filter_sb.accept_item(req_t'(pixel_if.req_type),
                                      {pixel_if.in_red, pixel_if.in_green, pixel_if.in_blue});
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d output pixels still awaited",
                     cycle_count, filter_sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // offer one item, with random idle cycles first; returns on the accepting edge
    // valid stays high afterwards so back-to-back items need no second assignment
    task automatic send_item(input req_t kind, input pixel_t pix);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pixel_if.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_if.valid    <= 1'b1;
        pixel_if.req_type <= kind;
        {pixel_if.in_red, pixel_if.in_green, pixel_if.in_blue} <= pix;
        do
            @(posedge clk);
        while (!pixel_if.ready);
    endtask

    // sender pauses until every awaited pixel has come out
    task automatic wait_results();
        pixel_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (filter_sb.pending() != 0);
    endtask

    // idle block: nothing awaited and the pipeline has had time to empty
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        filter_sb.write_register(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                             input logic [CFG_W-1:0] kt, input logic [CFG_W-1:0] km,
                             input logic [CFG_W-1:0] kb);
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
        write_reg(REG_KERNEL_TOP, kt);
        write_reg(REG_KERNEL_MIDDLE, km);
        write_reg(REG_KERNEL_BOTTOM, kb);
    endtask

    // kernel row, left coefficient in the low bits
    function automatic logic [CFG_W-1:0] pack_row(int left, int centre, int right);
        return CFG_W'({COEF_W'(right), COEF_W'(centre), COEF_W'(left)});
    endfunction

    function automatic int small_coef();
        return int'($urandom_range(0, 6)) - 3;
    endfunction

    // mostly small coefficients so sums stay in range, some extremes
    function automatic logic [CFG_W-1:0] random_kernel_row();
        case ($urandom_range(0, 9))
            5:       return CFG_W'($urandom());
            6:       return '0;
            7:       return pack_row(511, 511, 511);
            8:       return pack_row(-512, -512, -512);
            9:       return pack_row(-1, -1, -1);
            default: return pack_row(small_coef(), small_coef(), small_coef());
        endcase
    endfunction

    // geometry data sometimes carries junk above the field
    function automatic logic [CFG_W-1:0] geometry_word(int v, int field_w);
        logic [CFG_W-1:0] word;
        word = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom()) : '0;
        word = (word >> field_w) << field_w;
        return word | CFG_W'(v);
    endfunction

    // one frame in raster order with stray early drains, then width + 1 drain items,
    // some of them surplus pixels; a truncated frame stops partway through
    task automatic send_frame(input bit truncate, input bit pause_mid);
        int w;
        int n_px;
        int cut;
        int pause_at;
        int i;

        w        = filter_sb.active_width();
        n_px     = w * filter_sb.active_height();
        cut      = truncate ? int'($urandom_range(0, n_px - 1)) : n_px;
        pause_at = pause_mid ? int'($urandom_range(0, n_px - 1)) : -1;
        for (i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                send_item(REQ_DRAIN, pixel_t'($urandom()));
            if (i == pause_at)
                wait_results();
            send_item(REQ_PIXEL, pixel_t'($urandom()));
            stream_sent++;
        end
        if (!truncate)
        begin
            for (i = 0; i <= w; i++)
            begin
                send_item(($urandom_range(0, 99) < 15) ? REQ_PIXEL : REQ_DRAIN,
                          pixel_t'($urandom()));
                stream_sent++;
            end
        end
    endtask

    initial
    begin
        int  i;
        int  mode;
        int  phase_start;
        int  wv;
        int  hv;
        bit  first;
        bit  need_config;
        bit  truncate;

        pixel_if.valid    = 1'b0;
        pixel_if.req_type = REQ_PIXEL;
        pixel_if.in_red   = '0;
        pixel_if.in_green = '0;
        pixel_if.in_blue  = '0;
        filt_if.ready     = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_FRAME_WIDTH;
        cfg_data          = '0;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // values after reset: 1024 wide, identity kernel; a row and a bit gives a few outputs
        for (i = 0; i < 1040; i++)
            send_item(REQ_PIXEL, pixel_t'($urandom()));
        settle();

        // sharpening kernel on a 3 x 2 frame: saturation both ways, channel extremes,
        // an early drain and a surplus pixel in the drain run
        set_frame(3, 2, pack_row(-1, -1, -1), pack_row(-1, 9, -1), pack_row(-1, -1, -1));
        send_item(REQ_PIXEL, 24'h000000);
        send_item(REQ_DRAIN, 24'hFFFFFF);
        send_item(REQ_PIXEL, 24'hFFFFFF);
        send_item(REQ_PIXEL, 24'hFF0000);
        send_item(REQ_PIXEL, 24'h00FF00);
        send_item(REQ_PIXEL, 24'h0000FF);
        send_item(REQ_PIXEL, 24'h808080);
        send_item(REQ_PIXEL, 24'h5A5A5A);
        send_item(REQ_DRAIN, 24'h000000);
        send_item(REQ_DRAIN, 24'hFFFFFF);
        send_item(REQ_DRAIN, 24'h123456);
        settle();

        // zero width and zero height both behave as one
        set_frame(0, 0, '0, pack_row(0, 511, 0), '0);
        send_item(REQ_PIXEL, 24'h010001);
        send_item(REQ_DRAIN, 24'h000000);
        send_item(REQ_DRAIN, 24'h000000);
        settle();

        // writes past the register list change nothing; then a column of three
        for (i = 0; i < UNMAPPED_COUNT; i++)
            write_reg(REG_UNMAPPED_FIRST + i, CFG_W'($urandom()));
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_KERNEL_TOP, pack_row(0, -512, 0));
        send_item(REQ_PIXEL, 24'h020304);
        send_item(REQ_PIXEL, 24'hFFFFFF);
        send_item(REQ_PIXEL, 24'h000000);
        send_item(REQ_DRAIN, 24'h000000);
        send_item(REQ_DRAIN, 24'h000000);
        settle();

        // widest line, written as 2047 which is cut back to the line store size
        set_frame(2047, 1, random_kernel_row(), random_kernel_row(), random_kernel_row());
        send_frame(1'b0, 1'b0);
        settle();

        // full width exactly, two rows so both line stores span the whole line
        set_frame(1024, 2, pack_row(small_coef(), small_coef(), small_coef()),
                  pack_row(small_coef(), 4, small_coef()),
                  pack_row(small_coef(), small_coef(), small_coef()));
        send_frame(1'b0, 1'b0);
        settle();

        // tallest frame, abandoned after a few rows; extreme kernel words
        set_frame(4, 65535, pack_row(511, 511, 511), {CFG_W{1'b1}}, pack_row(-512, -512, -512));
        for (i = 0; i < 30; i++)
        begin
            send_item(REQ_PIXEL, pixel_t'($urandom()));
            stream_sent++;
        end

        // random frames over four idling phases: none, sender, receiver, both
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 59; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 59; end
                default: begin src_idle_pct = 33; snk_stall_pct = 33; end
            endcase
            phase_start = stream_sent;
            first       = 1'b1;
            need_config = 1'b1;
            while (stream_sent - phase_start < RANDOM_PHASE_ITEMS)
            begin
                if (need_config || $urandom_range(0, 1) == 0)
                begin
                    settle();
                    case ($urandom_range(0, 19))
                        0:       wv = 0;
                        1:       wv = $urandom_range(13, 40);
                        default: wv = $urandom_range(1, 12);
                    endcase
                    hv = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
                    // first frame of the first phase is big enough to fill the block
                    if (mode == 0 && first)
                    begin
                        wv = 12;
                        hv = 6;
                    end
                    set_frame(geometry_word(wv, FW_W), geometry_word(hv, FH_W),
                              random_kernel_row(), random_kernel_row(), random_kernel_row());
                end
                if (mode == 0 && first)
                    -> long_hold_go;
                truncate    = ($urandom_range(0, 9) == 0);
                send_frame(truncate, first);
                need_config = truncate;
                first       = 1'b0;
            end
        end

        // drain everything, then give stray outputs a chance to show up
        wait_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d items (%0d early drains ignored) over several frame shapes and kernels",
                 filter_sb.items_taken, filter_sb.drains_ignored);
        $display("checked %0d output pixels, %0d complete frames, %0d mismatches",
                 filter_sb.results_seen, filter_sb.frames_done, filter_sb.mismatches);
        if (filter_sb.mismatches == 0 && filter_sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
